/* hw/rtl/gmat_pkg.sv */
// ----------------------------------------------------------------------------
// gmat_pkg
// Shared widths and constants of the geared multi-turn angle tracker.
// ----------------------------------------------------------------------------
package gmat_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ANGLE_W   = 18;
    localparam int SHAFT_W   = 17;
    localparam int RATIO_W   = 16;

    // 180 and 360 degrees in fixed point
    localparam int HALF_TURN = 180 << FRAC_BITS;
    localparam int FULL_TURN = 360 << FRAC_BITS;
    localparam int TURN_W    = $clog2(FULL_TURN + 1);

    // Dividend: angle + (residue + 2 * ratio) * FULL_TURN, always positive.
    // Largest value is (65534 + 131070) * 92160 + 131071, below 2**35.
    localparam int DIV_W     = 35;
    localparam int CNT_W     = $clog2(DIV_W);

endpackage

/* hw/rtl/gmat_unwrap.sv */
// ----------------------------------------------------------------------------
// gmat_unwrap
// Turn unwrapping: compares each sample with the previous one and keeps the
// turn count modulo the gear ratio.
// ----------------------------------------------------------------------------
module gmat_unwrap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic                                i_step,
    input  logic [gmat_pkg::RATIO_W-1:0]        i_ratio,
    input  logic signed [gmat_pkg::ANGLE_W-1:0] i_angle,
    output logic [gmat_pkg::RATIO_W-1:0]        o_residue
);

    localparam logic signed [gmat_pkg::ANGLE_W:0] HALF_POS =
        (gmat_pkg::ANGLE_W+1)'(gmat_pkg::HALF_TURN);
    localparam logic signed [gmat_pkg::ANGLE_W:0] HALF_NEG =
        -(gmat_pkg::ANGLE_W+1)'(gmat_pkg::HALF_TURN);

    logic                                r_first;
    logic signed [gmat_pkg::ANGLE_W-1:0] r_prev;
    logic [gmat_pkg::RATIO_W-1:0]        r_residue;
    logic [gmat_pkg::RATIO_W-1:0]        n_residue;
    logic signed [gmat_pkg::ANGLE_W:0]   w_delta;
    logic [gmat_pkg::RATIO_W:0]          w_inc;

    assign w_delta = {i_angle[gmat_pkg::ANGLE_W-1], i_angle}
                   - {r_prev[gmat_pkg::ANGLE_W-1], r_prev};
    assign w_inc   = {1'b0, r_residue} + 1'b1;

    always_comb begin
        n_residue = r_residue;
        if (!r_first) begin
            if (w_delta > HALF_POS) begin
                // forward jump across the seam: one turn back
                n_residue = (r_residue == '0) ? i_ratio - 1'b1 : r_residue - 1'b1;
            end else if (w_delta < HALF_NEG) begin
                n_residue = (w_inc >= {1'b0, i_ratio}) ? '0 : w_inc[gmat_pkg::RATIO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_first   <= 1'b1;
            r_prev    <= '0;
            r_residue <= '0;
        end else if (i_step) begin
            r_first   <= 1'b0;
            r_prev    <= i_angle;
            r_residue <= n_residue;
        end
    end

    assign o_residue = r_residue;

endmodule

/* hw/rtl/gmat_div.sv */
// ----------------------------------------------------------------------------
// gmat_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// folded modulo one full turn as it is built, so only the wrapped angle is
// kept.
// ----------------------------------------------------------------------------
module gmat_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gmat_pkg::DIV_W-1:0]        i_dividend,
    input  logic [gmat_pkg::RATIO_W-1:0]      i_divisor,
    output logic                              o_done,
    output logic [gmat_pkg::TURN_W-1:0]       o_qmod
);

    localparam logic [gmat_pkg::TURN_W:0] FULL_V = (gmat_pkg::TURN_W+1)'(gmat_pkg::FULL_TURN);

    logic                              r_busy;
    logic                              r_done;
    logic [gmat_pkg::CNT_W-1:0]        r_cnt;
    logic [gmat_pkg::DIV_W-1:0]        r_num;
    logic [gmat_pkg::RATIO_W-1:0]      r_rem;
    logic [gmat_pkg::TURN_W-1:0]       r_qmod;

    logic [gmat_pkg::RATIO_W:0]        w_shift;
    logic                              w_ge;
    logic [gmat_pkg::RATIO_W:0]        w_sub;
    logic [gmat_pkg::TURN_W:0]         w_q2;
    logic [gmat_pkg::TURN_W:0]         w_q2_red;

    assign w_shift  = {r_rem, r_num[gmat_pkg::DIV_W-1]};
    assign w_ge     = (w_shift >= {1'b0, i_divisor});
    assign w_sub    = w_shift - {1'b0, i_divisor};
    assign w_q2     = {r_qmod, w_ge};
    assign w_q2_red = (w_q2 >= FULL_V) ? w_q2 - FULL_V : w_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= gmat_pkg::CNT_W'(gmat_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_rem  <= '0;
            r_qmod <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[gmat_pkg::DIV_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_sub[gmat_pkg::RATIO_W-1:0] : w_shift[gmat_pkg::RATIO_W-1:0];
            r_qmod <= w_q2_red[gmat_pkg::TURN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_qmod = r_qmod;

endmodule

/* hw/rtl/geared_multiturn_angle_tracker_top.sv */
// ----------------------------------------------------------------------------
// geared_multiturn_angle_tracker_top
// Multi-turn unwrap of a motor angle, scaled by the gear ratio to a shaft
// angle in (-180,180] degrees.
// ----------------------------------------------------------------------------
// Each motor angle (1/256 degree) is unwrapped against the previous sample,
// the turn count is held modulo the gear ratio, and the multi-turn angle is
// floor-divided by the ratio and wrapped to (-180,180]. After transfer, the
// S_MUL state forms the dividend with a single multiply, the bit-serial
// divider builds the quotient one bit per cycle, its done flag is handed
// back to the sequencer, and S_DONE loads the output register when it is
// empty or being read; the next sample can be taken once the sequencer is
// back in idle. Input ready is low from transfer until the result moves to
// the output register, and while a gear ratio write is offered; a result
// waiting there does not block the next sample. Writing the gear ratio (zero
// is taken as one) restarts tracking; the next sample only seeds.
// ----------------------------------------------------------------------------
module geared_multiturn_angle_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gmat_pkg::RATIO_W-1:0]        i_gear_ratio,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [gmat_pkg::ANGLE_W-1:0] i_motor_angle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gmat_pkg::SHAFT_W-1:0] o_shaft_angle
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [gmat_pkg::TURN_W-1:0] FULL_V = gmat_pkg::TURN_W'(gmat_pkg::FULL_TURN);
    localparam logic [gmat_pkg::TURN_W-1:0] HALF_V = gmat_pkg::TURN_W'(gmat_pkg::HALF_TURN);
    localparam int MUL_W  = gmat_pkg::RATIO_W + 2;
    localparam int PROD_W = MUL_W + gmat_pkg::TURN_W;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic [gmat_pkg::RATIO_W-1:0]        r_ratio;
    logic signed [gmat_pkg::ANGLE_W-1:0] r_angle;
    logic                                r_out_valid;
    logic signed [gmat_pkg::SHAFT_W-1:0] r_shaft;

    logic                                w_cfg_xfer;
    logic                                w_in_xfer;
    logic                                w_load_out;
    logic [gmat_pkg::RATIO_W-1:0]        w_residue;
    logic [MUL_W-1:0]                    w_res2;
    logic [PROD_W-1:0]                   w_prod;
    logic [gmat_pkg::DIV_W:0]            w_total;
    logic                                w_div_done;
    logic [gmat_pkg::TURN_W-1:0]         w_qmod;
    logic [gmat_pkg::TURN_W:0]           w_wrapped;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer   = i_valid && o_ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= gmat_pkg::RATIO_W'(1);
        end else if (w_cfg_xfer) begin
            r_ratio <= (i_gear_ratio == '0) ? gmat_pkg::RATIO_W'(1) : i_gear_ratio;
        end
    end

    gmat_unwrap u_unwrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_cfg_xfer),
        .i_step    (w_in_xfer),
        .i_ratio   (r_ratio),
        .i_angle   (i_motor_angle),
        .o_residue (w_residue)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_angle <= i_motor_angle;
        end
    end

    // offset by two full turns per ratio step keeps the dividend positive
    assign w_res2  = {2'b00, w_residue} + {1'b0, r_ratio, 1'b0};
    assign w_prod  = PROD_W'(w_res2) * PROD_W'(gmat_pkg::FULL_TURN);
    assign w_total = (gmat_pkg::DIV_W+1)'(w_prod)
                   + {{(gmat_pkg::DIV_W+1-gmat_pkg::ANGLE_W){r_angle[gmat_pkg::ANGLE_W-1]}},
                      r_angle};

    gmat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL),
        .i_dividend (w_total[gmat_pkg::DIV_W-1:0]),
        .i_divisor  (r_ratio),
        .o_done     (w_div_done),
        .o_qmod     (w_qmod)
    );

    // fold [0,360) into (-180,180]
    assign w_wrapped = (w_qmod > HALF_V) ? {1'b0, w_qmod} - {1'b0, FULL_V} : {1'b0, w_qmod};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_shaft <= w_wrapped[gmat_pkg::SHAFT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_shaft_angle = r_shaft;

endmodule
